### rtl/opd_pkg.sv
// Shared types, codes and the byte-wide CRC-32 step for the Ogg page deframer.
// Used by every module of the deframer; depends on nothing else.
`default_nettype none

package opd_pkg;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

  // Byte offsets inside the fixed 27-byte page header.
  localparam logic [15:0] POS_FLAGS       = 16'd5;
  localparam logic [15:0] POS_VERSION     = 16'd4;
  localparam logic [15:0] POS_CAPTURE_END = 16'd4;
  localparam logic [15:0] POS_GRANULE_END = 16'd14;
  localparam logic [15:0] POS_SERIAL_END  = 16'd18;
  localparam logic [15:0] POS_SEQ_END     = 16'd22;
  localparam logic [15:0] POS_CRC_FIRST   = 16'd22;
  localparam logic [15:0] POS_CRC_END     = 16'd26;
  localparam logic [16:0] POS_HEADER_LAST = 17'd26;

  localparam logic [7:0] CAPTURE [4] = '{8'h4F, 8'h67, 8'h67, 8'h53};

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LACES  = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BODY  = 2'd0,
    KIND_PAGE  = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CAPTURE   = 3'd1,
    ST_VERSION   = 3'd2,
    ST_FLAGS     = 3'd3,
    ST_CHECKSUM  = 3'd4,
    ST_TRUNCATED = 3'd5
  } status_t;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  body_byte;
    logic [63:0] page_granule;
    logic [31:0] page_serial;
    logic [31:0] page_sequence;
    logic [2:0]  header_flags;
    logic [7:0]  segment_count;
    logic [15:0] body_length;
    status_t     status;
  } result_t;

  // One byte of CRC-32, MSB first, no reflection.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/opd_in_reg.sv
// Input register of the Ogg page deframer: holds one request until the step logic takes it.
// Depends on opd_pkg for the item type.
`default_nettype none

module opd_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_stall,
  input  wire opd_pkg::item_t item_in,
  input  wire logic          advance,
  output logic               held_valid,
  output opd_pkg::item_t     held_item
);
  import opd_pkg::*;

  assign item_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!item_stall) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall) begin
      held_item <= item_in;
    end
  end

endmodule

`default_nettype wire

### rtl/opd_step.sv
// Page parsing state and the combinational step logic of the Ogg page deframer.
// Depends on opd_pkg for codes, types and the CRC byte update.
`default_nettype none

module opd_step (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  wire opd_pkg::item_t item,
  output logic                res_valid,
  output opd_pkg::result_t    res
);
  import opd_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] byte_position, byte_position_next;
  logic [7:0]  laces_expected, laces_expected_next;
  logic [15:0] body_total, body_total_next;
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] stored_checksum, stored_checksum_next;
  logic [63:0] granule_reg, granule_reg_next;
  logic [31:0] serial_reg, serial_reg_next;
  logic [31:0] sequence_reg, sequence_reg_next;
  logic [2:0]  flags_reg, flags_reg_next;
  status_t     sticky_error, sticky_error_next;
  status_t     header_fault, header_fault_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      byte_position   <= '0;
      laces_expected  <= '0;
      body_total      <= '0;
      running_crc     <= '0;
      stored_checksum <= '0;
      granule_reg     <= '0;
      serial_reg      <= '0;
      sequence_reg    <= '0;
      flags_reg       <= '0;
      sticky_error    <= ST_OK;
      header_fault    <= ST_OK;
    end else if (fire) begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      laces_expected  <= laces_expected_next;
      body_total      <= body_total_next;
      running_crc     <= running_crc_next;
      stored_checksum <= stored_checksum_next;
      granule_reg     <= granule_reg_next;
      serial_reg      <= serial_reg_next;
      sequence_reg    <= sequence_reg_next;
      flags_reg       <= flags_reg_next;
      sticky_error    <= sticky_error_next;
      header_fault    <= header_fault_next;
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic [15:0] pos;
    logic        do_finish;
    logic [7:0]  finish_byte;
    status_t     hf;

    b           = item.data_byte;
    pos         = byte_position;
    do_finish   = 1'b0;
    finish_byte = '0;
    hf          = header_fault;

    phase_next           = phase;
    byte_position_next   = byte_position;
    laces_expected_next  = laces_expected;
    body_total_next      = body_total;
    running_crc_next     = running_crc;
    stored_checksum_next = stored_checksum;
    granule_reg_next     = granule_reg;
    serial_reg_next      = serial_reg;
    sequence_reg_next    = sequence_reg;
    flags_reg_next       = flags_reg;
    sticky_error_next    = sticky_error;
    header_fault_next    = header_fault;
    res_valid            = 1'b0;
    res                  = '0;

    if (sticky_error != ST_OK) begin
      res_valid  = 1'b1;
      res.kind   = KIND_ERROR;
      res.status = sticky_error;
    end else if (item.action) begin
      res_valid = 1'b1;
      if (pos != '0) begin
        sticky_error_next = ST_TRUNCATED;
        res.kind          = KIND_ERROR;
        res.status        = ST_TRUNCATED;
      end else begin
        res.kind = KIND_END;
      end
    end else begin
      // The four checksum bytes enter the CRC as zero.
      running_crc_next   = crc_byte(running_crc,
                                    (pos >= POS_CRC_FIRST && pos < POS_CRC_END) ? 8'h00 : b);
      byte_position_next = pos + 16'd1;

      unique case (phase)
        PH_LACES: begin
          body_total_next = body_total + {8'h00, b};
          if ({1'b0, pos} == POS_HEADER_LAST + {9'h000, laces_expected}) begin
            if (body_total_next == '0) begin
              do_finish = 1'b1;
            end else begin
              phase_next = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if ({1'b0, pos} == POS_HEADER_LAST + {9'h000, laces_expected}
                             + {1'b0, body_total}) begin
            do_finish   = 1'b1;
            finish_byte = b;
          end else begin
            res_valid     = 1'b1;
            res.kind      = KIND_BODY;
            res.body_byte = b;
          end
        end
        default: begin
          // Header phase; the unused phase code behaves the same way.
          if (pos < POS_CAPTURE_END) begin
            if (pos == '0) begin
              hf = ST_OK;
            end
            if (b != CAPTURE[pos[1:0]] && hf == ST_OK) begin
              hf = ST_CAPTURE;
            end
            header_fault_next = hf;
          end else if (pos == POS_VERSION) begin
            if (b != 8'h00 && hf == ST_OK) begin
              header_fault_next = ST_VERSION;
            end
          end else if (pos == POS_FLAGS) begin
            if (b[7:3] != 5'b0 && hf == ST_OK) begin
              header_fault_next = ST_FLAGS;
            end
            flags_reg_next = b[2:0];
          end else if (pos < POS_GRANULE_END) begin
            granule_reg_next = {b, granule_reg[63:8]};
          end else if (pos < POS_SERIAL_END) begin
            serial_reg_next = {b, serial_reg[31:8]};
          end else if (pos < POS_SEQ_END) begin
            sequence_reg_next = {b, sequence_reg[31:8]};
          end else if (pos < POS_CRC_END) begin
            stored_checksum_next = {b, stored_checksum[31:8]};
          end else if (header_fault != ST_OK) begin
            // Header faults wait for the lace count byte, first fault wins.
            sticky_error_next = header_fault;
            res_valid         = 1'b1;
            res.kind          = KIND_ERROR;
            res.status        = header_fault;
          end else begin
            laces_expected_next = b;
            body_total_next     = '0;
            if (b == 8'h00) begin
              do_finish = 1'b1;
            end else begin
              phase_next = PH_LACES;
            end
          end
        end
      endcase

      if (do_finish) begin
        res_valid          = 1'b1;
        res.body_byte      = finish_byte;
        res.page_granule   = granule_reg_next;
        res.page_serial    = serial_reg_next;
        res.page_sequence  = sequence_reg_next;
        res.header_flags   = flags_reg_next;
        res.segment_count  = laces_expected_next;
        res.body_length    = body_total_next;
        if (running_crc_next == stored_checksum_next) begin
          res.kind            = KIND_PAGE;
          res.status          = ST_OK;
          phase_next          = PH_HEADER;
          byte_position_next  = '0;
          laces_expected_next = '0;
          body_total_next     = '0;
          running_crc_next    = '0;
          header_fault_next   = ST_OK;
        end else begin
          res.kind          = KIND_ERROR;
          res.status        = ST_CHECKSUM;
          sticky_error_next = ST_CHECKSUM;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/opd_out_reg.sv
// Result register of the Ogg page deframer: holds one result until the receiver takes it.
// Depends on opd_pkg for the result type.
`default_nettype none

module opd_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire opd_pkg::result_t res_in,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output opd_pkg::result_t      res_out,
  output logic                  can_load
);
  import opd_pkg::*;

  assign can_load = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (can_load) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      res_out <= res_in;
    end
  end

endmodule

`default_nettype wire

### rtl/ogg_page_deframer.sv
// Ogg page deframer: header checks, lace sum, CRC-32 page check and body forwarding.
// Top level; instantiates opd_in_reg, opd_step and opd_out_reg, uses opd_pkg.
//
// Use: the item channel (item_valid, item_stall, action, data_byte) carries one stream
// byte, or an end-of-stream check when action is 1. The result channel (result_valid,
// result_stall and the result fields) carries forwarded body bytes, one verdict per
// page, error reports and the clean end-of-stream answer. Header and lace bytes other
// than a page's last give no result. A request is taken at an edge where valid is high
// and stall is low. Throughput is one byte per cycle while result_stall is low: the
// CRC byte update, header field capture and the end-of-page compares all sit in one
// combinational step between the input register and the result register. When
// result_stall holds a waiting result, the step stops; one further request is held in
// the input register, and then item_stall rises. Reset clears the parse state and the
// sticky error and empties both registers. Once an error is reported, every later
// request answers with that error until reset. Body bytes go out before the page
// checksum is known, so the consumer drops any page that ends in an error.
`default_nettype none

module ogg_page_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic        action,
  input  wire logic [7:0]  data_byte,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [1:0]       kind,
  output logic [7:0]       body_byte,
  output logic [63:0]      page_granule,
  output logic [31:0]      page_serial,
  output logic [31:0]      page_sequence,
  output logic [2:0]       header_flags,
  output logic [7:0]       segment_count,
  output logic [15:0]      body_length,
  output logic [2:0]       status
);
  import opd_pkg::*;

  item_t   item_in;
  item_t   held_item;
  logic    held_valid;
  logic    can_load;
  logic    fire;
  logic    step_valid;
  result_t step_res;
  result_t res_out;

  assign item_in.action    = action;
  assign item_in.data_byte = data_byte;
  assign fire              = held_valid && can_load;

  opd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item_in    (item_in),
    .advance    (can_load),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  opd_step u_step (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (held_item),
    .res_valid (step_valid),
    .res       (step_res)
  );

  opd_out_reg u_out_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (fire && step_valid),
    .res_in       (step_res),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .res_out      (res_out),
    .can_load     (can_load)
  );

  assign kind          = res_out.kind;
  assign body_byte     = res_out.body_byte;
  assign page_granule  = res_out.page_granule;
  assign page_serial   = res_out.page_serial;
  assign page_sequence = res_out.page_sequence;
  assign header_flags  = res_out.header_flags;
  assign segment_count = res_out.segment_count;
  assign body_length   = res_out.body_length;
  assign status        = res_out.status;

endmodule

`default_nettype wire
